/* rtl/sgjd_pkg.sv */
// ----------------------------------------------------------------------------
// sgjd_pkg
// Shared types and constants for the jump-divstep matrix unit.
// ----------------------------------------------------------------------------
package sgjd_pkg;

	// Field widths of one request and one result
	localparam int DELTA_W     = 32;
	localparam int LOW_W       = 32;
	localparam int STEP_W      = 5;
	localparam int MAT_W       = 32;

	// Packed stream widths, filled up to whole bytes
	localparam int IN_FIELDS_W = DELTA_W + 2 * LOW_W + STEP_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 4 * MAT_W + DELTA_W;

	// Controller states
	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;     // take operands, reset the matrix to identity
		logic step;     // run one half-divstep
		logic capture;  // copy the finished matrix into the output register
	} dp_cmd_t;

endpackage

/* rtl/safegcd_jump_divstep.sv */
// ----------------------------------------------------------------------------
// safegcd_jump_divstep
// Jump-divstep matrix unit: runs a batch of constant-time half-divsteps on
// the low words of f and g and returns the transition matrix and new delta.
// ----------------------------------------------------------------------------
// An item is handled in order: its operands are loaded, each divstep runs
// through the single step unit, and the finished matrix is moved into the
// output register once that register is free. The output register holds a
// result while the next item is accepted and worked on; a new item is taken
// only once the previous one has left the step unit. Words are WORD_BITS
// wide inside; delta is sign-extended and f, g zero-extended to that width,
// and each result carries the low 32 bits of its word.
module safegcd_jump_divstep
	import sgjd_pkg::*;
#(
	parameter int WORD_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // delta_in, f_low, g_low, step_count, zero fill
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // mat_u, mat_v, mat_q, mat_r, delta_out
);

	logic [DELTA_W-1:0] delta_in;
	logic [LOW_W-1:0]   f_low;
	logic [LOW_W-1:0]   g_low;
	logic [STEP_W-1:0]  step_count;
	logic [MAT_W-1:0]   mat_u, mat_v, mat_q, mat_r;
	logic [DELTA_W-1:0] delta_out;
	dp_cmd_t            cmd;

	// Unpack the request
	assign delta_in   = s_tdata[DELTA_W-1:0];
	assign f_low      = s_tdata[DELTA_W +: LOW_W];
	assign g_low      = s_tdata[DELTA_W+LOW_W +: LOW_W];
	assign step_count = s_tdata[DELTA_W+2*LOW_W +: STEP_W];

	// Pack the result
	assign m_tdata = {delta_out, mat_r, mat_q, mat_v, mat_u};

	sgjd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.step_count (step_count),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.cmd        (cmd)
	);

	sgjd_dp #(
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.delta_in  (delta_in),
		.f_low     (f_low),
		.g_low     (g_low),
		.mat_u     (mat_u),
		.mat_v     (mat_v),
		.mat_q     (mat_q),
		.mat_r     (mat_r),
		.delta_out (delta_out)
	);

endmodule

/* rtl/sgjd_ctrl.sv */
// ----------------------------------------------------------------------------
// sgjd_ctrl
// Controller: accepts a request, counts the divsteps and hands the result
// to the output register once that register is free.
// ----------------------------------------------------------------------------
module sgjd_ctrl
	import sgjd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [STEP_W-1:0] step_count,
	output logic              out_valid,
	input  logic              out_ready,
	output dp_cmd_t           cmd
);

	state_t            state_q;
	state_t            state_d;
	logic [STEP_W-1:0] cnt_q;
	logic              out_valid_q;
	logic              out_free;
	logic              accept;
	logic              steps_done;

	assign out_free   = !out_valid_q || out_ready;
	assign accept     = in_valid && in_ready;
	assign steps_done = (cnt_q == '0);
	assign out_valid  = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (steps_done && out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.step    = 1'b0;
		cmd.capture = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_RUN: begin
				cmd.step    = !steps_done;
				cmd.capture = steps_done && out_free;
			end
			default: ;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Load the step counter, count it down once per divstep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= step_count;
		end else if (cmd.step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Hold the result valid until the item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.capture) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* rtl/sgjd_dp.sv */
// ----------------------------------------------------------------------------
// sgjd_dp
// Datapath: working registers for f, g, delta and the 2x2 matrix, one
// half-divstep unit, and the output register.
// ----------------------------------------------------------------------------
module sgjd_dp
	import sgjd_pkg::*;
#(
	parameter int WORD_BITS = 32
) (
	input  logic               clk,
	input  dp_cmd_t            cmd,
	input  logic [DELTA_W-1:0] delta_in,
	input  logic [LOW_W-1:0]   f_low,
	input  logic [LOW_W-1:0]   g_low,
	output logic [MAT_W-1:0]   mat_u,
	output logic [MAT_W-1:0]   mat_v,
	output logic [MAT_W-1:0]   mat_q,
	output logic [MAT_W-1:0]   mat_r,
	output logic [DELTA_W-1:0] delta_out
);

	logic [WORD_BITS-1:0] d_q, f_q, g_q, u_q, v_q, q_q, r_q;
	logic [WORD_BITS-1:0] f_sel, u_sel, v_sel;
	logic [WORD_BITS-1:0] g_add, q_add, r_add;
	logic [WORD_BITS-1:0] d_nxt, f_nxt, u_nxt, v_nxt;
	logic                 odd, swap;

	// One half-divstep
	always_comb begin
		odd   = g_q[0];
		swap  = odd && d_q[WORD_BITS-1];
		f_sel = swap ? (~f_q + 1'b1) : f_q;
		u_sel = swap ? (~u_q + 1'b1) : u_q;
		v_sel = swap ? (~v_q + 1'b1) : v_q;
		g_add = odd ? (g_q + f_sel) : g_q;
		q_add = odd ? (q_q + u_sel) : q_q;
		r_add = odd ? (r_q + v_sel) : r_q;
		d_nxt = (swap ? ~d_q : d_q) - 1'b1;
		f_nxt = swap ? (f_q + g_add) : f_q;
		u_nxt = swap ? (u_q + q_add) : u_q;
		v_nxt = swap ? (v_q + r_add) : v_q;
	end

	// Load operands or advance one step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d_q <= WORD_BITS'(signed'(delta_in));
			f_q <= WORD_BITS'(f_low);
			g_q <= WORD_BITS'(g_low);
			u_q <= WORD_BITS'(1);
			v_q <= '0;
			q_q <= '0;
			r_q <= WORD_BITS'(1);
		end else if (cmd.step) begin
			d_q <= d_nxt;
			f_q <= f_nxt;
			g_q <= g_add >> 1;
			u_q <= u_nxt << 1;
			v_q <= v_nxt << 1;
			q_q <= q_add;
			r_q <= r_add;
		end
	end

	// Output register, low word of each entry
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mat_u     <= MAT_W'(u_q);
			mat_v     <= MAT_W'(v_q);
			mat_q     <= MAT_W'(q_q);
			mat_r     <= MAT_W'(r_q);
			delta_out <= DELTA_W'(d_q);
		end
	end

endmodule
